FILE: hw/rtl/hprc_pkg.sv
package hprc_pkg;

  // Width of the configuration write port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Full-scale level in percent.
  localparam logic [6:0] LEVEL_FULL = 7'd100;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_AUTO_MODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_START_LEVEL  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_STOP_LEVEL   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MIN_INTERVAL = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_HIGH  = 3'd4;

  // Configuration reset values.
  localparam logic        RST_AUTO_MODE    = 1'b0;
  localparam logic [6:0]  RST_START_LEVEL  = 7'd20;
  localparam logic [6:0]  RST_STOP_LEVEL   = 7'd80;
  localparam logic [31:0] RST_MIN_INTERVAL = 32'd5000;
  localparam logic        RST_ACTIVE_HIGH  = 1'b1;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_MANUAL = 2'd2
  } op_e;

  typedef struct packed {
    logic        auto_mode;
    logic [6:0]  start_level;
    logic [6:0]  stop_level;
    logic [31:0] min_interval_ticks;
    logic        active_high;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] level;
    logic               command_on;
  } item_t;

  typedef struct packed {
    logic pump_on;
    logic relay_level;
    logic switched;
    logic refused;
  } res_t;

endpackage

FILE: hw/rtl/hprc_req_if.sv
interface hprc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] level;
  logic               command_on;

  modport source (output valid, output operation, output level, output command_on,
                  input ready);
  modport sink   (input valid, input operation, input level, input command_on,
                  output ready);
endinterface

FILE: hw/rtl/hprc_rsp_if.sv
interface hprc_rsp_if;
  logic valid;
  logic ready;
  logic pump_on;
  logic relay_level;
  logic switched;
  logic refused;

  modport source (output valid, output pump_on, output relay_level, output switched,
                  output refused, input ready);
  modport sink   (input valid, input pump_on, input relay_level, input switched,
                  input refused, output ready);
endinterface

FILE: hw/rtl/hprc_decide.sv
module hprc_decide (
  input  hprc_pkg::cfg_t  cfg_i,
  input  hprc_pkg::item_t item_i,
  input  logic            pump_i,
  input  logic [31:0]     elapsed_i,
  output logic            pump_o,
  output logic [31:0]     elapsed_o,
  output hprc_pkg::res_t  res_o
);

  logic [6:0] start_c, stop_c, lo, hi, lv;
  logic       want_vld, want;
  logic       allowed;

  // Clamp the thresholds to full scale and order them.
  always_comb begin
    start_c = (cfg_i.start_level > hprc_pkg::LEVEL_FULL) ? hprc_pkg::LEVEL_FULL
                                                         : cfg_i.start_level;
    stop_c  = (cfg_i.stop_level > hprc_pkg::LEVEL_FULL) ? hprc_pkg::LEVEL_FULL
                                                        : cfg_i.stop_level;
    lo = (start_c > stop_c) ? stop_c : start_c;
    hi = (start_c > stop_c) ? start_c : stop_c;
  end

  // Clamp the signed sample to 0..100.
  always_comb begin
    if (item_i.level[15]) begin
      lv = 7'd0;
    end else if (item_i.level > 16'sd100) begin
      lv = hprc_pkg::LEVEL_FULL;
    end else begin
      lv = item_i.level[6:0];
    end
  end

  assign allowed = (elapsed_i >= cfg_i.min_interval_ticks);

  // Work out the requested state, then apply the lockout.
  always_comb begin
    want_vld  = 1'b0;
    want      = 1'b0;
    elapsed_o = elapsed_i;
    case (item_i.operation)
      hprc_pkg::OP_TICK: begin
        if (elapsed_i != '1) begin
          elapsed_o = elapsed_i + 32'd1;
        end
      end
      hprc_pkg::OP_SAMPLE: begin
        if (cfg_i.auto_mode) begin
          if (lv <= lo) begin
            want_vld = 1'b1;
            want     = 1'b1;
          end else if (lv >= hi) begin
            want_vld = 1'b1;
            want     = 1'b0;
          end
        end
      end
      hprc_pkg::OP_MANUAL: begin
        want_vld = 1'b1;
        want     = item_i.command_on;
      end
      default: begin
      end
    endcase

    pump_o       = pump_i;
    res_o.switched = 1'b0;
    res_o.refused  = 1'b0;
    if (want_vld && (want != pump_i)) begin
      if (allowed) begin
        pump_o         = want;
        elapsed_o      = 32'd0;
        res_o.switched = 1'b1;
      end else begin
        res_o.refused  = 1'b1;
      end
    end
    res_o.pump_on     = pump_o;
    res_o.relay_level = (pump_o == cfg_i.active_high);
  end

endmodule

FILE: hw/rtl/hysteresis_pump_relay_control.sv
// Pump relay controller with level hysteresis and a minimum switch interval.
// A request passes the input register and then the result register. Throughput:
// one request per cycle when not stalled; the elapsed-tick counter and pump state
// update in the single compute stage, so back-to-back requests see each other.
// Reset: pump off, elapsed counter zero, registers at their defaults, no
// request or result in flight.
module hysteresis_pump_relay_control (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hprc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hprc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  hprc_req_if.sink                       req_i,
  hprc_rsp_if.source                     rsp_o
);

  hprc_pkg::cfg_t  cfg_q;
  hprc_pkg::item_t item_q;
  hprc_pkg::res_t  res_d, res_q;
  logic            s1_valid_q, out_valid_q;
  logic            pump_q, pump_d;
  logic [31:0]     elapsed_q, elapsed_d;
  logic            adv, fire, in_ready;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_mode          <= hprc_pkg::RST_AUTO_MODE;
      cfg_q.start_level        <= hprc_pkg::RST_START_LEVEL;
      cfg_q.stop_level         <= hprc_pkg::RST_STOP_LEVEL;
      cfg_q.min_interval_ticks <= hprc_pkg::RST_MIN_INTERVAL;
      cfg_q.active_high        <= hprc_pkg::RST_ACTIVE_HIGH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hprc_pkg::REG_AUTO_MODE:    cfg_q.auto_mode          <= cfg_wdata_i[0];
        hprc_pkg::REG_START_LEVEL:  cfg_q.start_level        <= cfg_wdata_i[6:0];
        hprc_pkg::REG_STOP_LEVEL:   cfg_q.stop_level         <= cfg_wdata_i[6:0];
        hprc_pkg::REG_MIN_INTERVAL: cfg_q.min_interval_ticks <= cfg_wdata_i[31:0];
        hprc_pkg::REG_ACTIVE_HIGH:  cfg_q.active_high        <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the compute stage advances when the result slot is free or drained.
  assign adv         = !out_valid_q || rsp_o.ready;
  assign fire        = s1_valid_q && adv;
  assign in_ready    = !s1_valid_q || adv;
  assign req_i.ready = in_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      item_q.operation  <= req_i.operation;
      item_q.level      <= req_i.level;
      item_q.command_on <= req_i.command_on;
    end
  end

  // Decision logic for one request.
  hprc_decide u_decide (
    .cfg_i     (cfg_q),
    .item_i    (item_q),
    .pump_i    (pump_q),
    .elapsed_i (elapsed_q),
    .pump_o    (pump_d),
    .elapsed_o (elapsed_d),
    .res_o     (res_d)
  );

  // Controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_q    <= 1'b0;
      elapsed_q <= 32'd0;
    end else if (fire) begin
      pump_q    <= pump_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pump_on     = res_q.pump_on;
  assign rsp_o.relay_level = res_q.relay_level;
  assign rsp_o.switched    = res_q.switched;
  assign rsp_o.refused     = res_q.refused;

`ifndef SYNTHESIS
  // A result never reports both a switch and a refusal.
  a_sw_ref_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.switched && res_q.refused))
    else $error("switched and refused both set");

  // A switch restarts the interval counter.
  a_sw_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_d.switched) |=> (elapsed_q == 32'd0))
    else $error("elapsed counter not cleared on switch");

  // The pump state only moves with a reported switch.
  a_pump_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pump_q != $past(pump_q)) |-> $past(fire && res_d.switched))
    else $error("pump state changed without a switch");

  // A shown result carries a pin level consistent with the polarity.
  a_relay_pol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.relay_level == (res_q.pump_on == cfg_q.active_high)))
    else $error("relay level does not match polarity");
`endif

endmodule
